// ===== rtl/core/uvst_pkg.sv =====
// Shared types and codes for the unique value set table.
// Holds the request and response payloads and the controller/datapath interface.
// No dependencies.
package uvst_pkg;

   localparam int unsigned OP_W     = 2;
   localparam int unsigned VALUE_W  = 32;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned POS_W    = 6;
   localparam int unsigned COUNT_W  = 7;

   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_DUP      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]           operation;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [POS_W-1:0]    position;
      logic [COUNT_W-1:0]  entry_count;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic load;    // capture the request, rewind the walk pointer
      logic scan;    // one step of the search walk
      logic shift;   // one step of the compaction walk
      logic commit;  // decide, update count and table, load the response
   } ctl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic hit;       // entry just read equals the request value
      logic walk_end;  // no read in flight and pointer at the count
      logic remove;    // captured request is a remove
   } ctl_stat_type;

endpackage

// ===== rtl/core/uvst_ctrl.sv =====
// Sequencing state machine for the unique value set table.
// Drives command strobes into uvst_datapath and owns the response valid flag.
// Depends on uvst_pkg.
module uvst_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  uvst_pkg::ctl_stat_type stat,
   output uvst_pkg::ctl_cmd_type  cmd
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_SHIFT  = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.hit) begin
               state_in = stat.remove ? S_SHIFT : S_FINISH;
            end else if (stat.walk_end) begin
               state_in = S_FINISH;
            end
         end
         S_SHIFT: begin
            cmd.shift = 1'b1;
            if (stat.walk_end) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            // hold until the response slot is free or being drained
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/core/uvst_datapath.sv =====
// Datapath of the unique value set table: entry memory, walk pointer,
// entry count and response register. Commanded by uvst_ctrl; depends on uvst_pkg.
module uvst_datapath #(
   parameter int unsigned CAPACITY = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  uvst_pkg::req_type      req_data,
   input  uvst_pkg::ctl_cmd_type  cmd,
   output uvst_pkg::ctl_stat_type stat,
   output uvst_pkg::rsp_type      rsp_data
);

   localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

   logic [uvst_pkg::VALUE_W-1:0] entries_mem [CAPACITY];

   logic [uvst_pkg::OP_W-1:0]    op_ff;
   logic [uvst_pkg::VALUE_W-1:0] value_ff;
   logic [uvst_pkg::VALUE_W-1:0] rd_data_ff;
   logic [CNT_W-1:0]             count_ff;
   logic [CNT_W-1:0]             count_in;
   logic [CNT_W-1:0]             ptr_ff;
   logic [IDX_W-1:0]             src_ff;
   logic                         pend_ff;
   logic                         hit_ff;
   logic [IDX_W-1:0]             hit_idx_ff;
   uvst_pkg::rsp_type            rsp_ff;
   uvst_pkg::rsp_type            rsp_in;

   logic                         hit;
   logic                         ptr_lt_count;
   logic                         rd_en;
   logic                         full;
   logic                         wr_en;
   logic [IDX_W-1:0]             wr_addr;
   logic [uvst_pkg::VALUE_W-1:0] wr_data;
   logic                         ins_ok;
   logic [IDX_W-1:0]             pos_idx;
   logic [IDX_W+uvst_pkg::POS_W-1:0]   pos_wide;
   logic [CNT_W+uvst_pkg::COUNT_W-1:0] cnt_wide;

   assign hit          = pend_ff && (rd_data_ff == value_ff);
   assign ptr_lt_count = ptr_ff < count_ff;
   assign full         = count_ff == CNT_W'(CAPACITY);
   assign rd_en        = (cmd.shift || (cmd.scan && !hit)) && ptr_lt_count;

   assign stat.hit      = hit;
   assign stat.walk_end = !pend_ff && !ptr_lt_count;
   assign stat.remove   = op_ff == uvst_pkg::OP_REMOVE;

   // Commit decision
   always_comb begin
      ins_ok          = 1'b0;
      count_in        = count_ff;
      pos_idx         = '0;
      rsp_in.status   = uvst_pkg::ST_NOTFOUND;
      case (op_ff)
         uvst_pkg::OP_LOOKUP: begin
            if (hit_ff) begin
               rsp_in.status = uvst_pkg::ST_OK;
               pos_idx       = hit_idx_ff;
            end
         end
         uvst_pkg::OP_INSERT: begin
            if (hit_ff) begin
               rsp_in.status = uvst_pkg::ST_DUP;
            end else if (full) begin
               rsp_in.status = uvst_pkg::ST_FULL;
            end else begin
               rsp_in.status = uvst_pkg::ST_OK;
               ins_ok        = 1'b1;
               pos_idx       = count_ff[IDX_W-1:0];
               count_in      = count_ff + CNT_W'(1);
            end
         end
         uvst_pkg::OP_REMOVE: begin
            if (hit_ff) begin
               rsp_in.status = uvst_pkg::ST_OK;
               pos_idx       = hit_idx_ff;
               count_in      = count_ff - CNT_W'(1);
            end
         end
         default: begin
            rsp_in.status = uvst_pkg::ST_NOTFOUND;
         end
      endcase
      pos_wide           = {{uvst_pkg::POS_W{1'b0}}, pos_idx};
      cnt_wide           = {{uvst_pkg::COUNT_W{1'b0}}, count_in};
      rsp_in.position    = pos_wide[uvst_pkg::POS_W-1:0];
      rsp_in.entry_count = cnt_wide[uvst_pkg::COUNT_W-1:0];
   end

   // Single write port: append on insert, otherwise move an entry down one place
   always_comb begin
      if (cmd.commit && ins_ok) begin
         wr_en   = 1'b1;
         wr_addr = count_ff[IDX_W-1:0];
         wr_data = value_ff;
      end else begin
         wr_en   = cmd.shift && pend_ff;
         wr_addr = src_ff - IDX_W'(1);
         wr_data = rd_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= entries_mem[ptr_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         if (cmd.load) begin
            pend_ff <= 1'b0;
         end else if (cmd.scan && hit) begin
            pend_ff <= 1'b0;
         end else if (cmd.scan || cmd.shift) begin
            pend_ff <= rd_en;
         end
         if (cmd.commit) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_data.operation;
         value_ff <= req_data.value;
         ptr_ff   <= '0;
         hit_ff   <= 1'b0;
      end else if (cmd.scan && hit) begin
         // restart the walk just past the match for a possible compaction
         hit_ff     <= 1'b1;
         hit_idx_ff <= src_ff;
         ptr_ff     <= CNT_W'(src_ff) + CNT_W'(1);
      end else if (rd_en) begin
         src_ff <= ptr_ff[IDX_W-1:0];
         ptr_ff <= ptr_ff + CNT_W'(1);
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== rtl/core/unique_value_set_table_unit.sv =====
// Top level of the unique value set table: a packed table of distinct 32-bit values.
// Instantiates uvst_ctrl and uvst_datapath; depends on uvst_pkg.
//
// Each request transaction carries an operation (lookup, insert if absent,
// remove if present) and a signed 32-bit value, and yields exactly one response
// transaction with a status, the entry position and the entry count after the
// operation. Entries live in a single-port-write, single-port-read memory of
// CAPACITY words, kept packed in slots 0 to count-1. The search walks the table
// one entry per cycle through the registered memory read. A remove then compacts
// the table, moving each later entry down one slot per cycle. A registered read
// comes ahead of each compare or move. The table memory needs no clearing after
// reset: only slots below the count are ever read. A finished response waits in
// an output register, and a new request is taken while it waits; the following
// response is held back until the register drains. Operation code 3 is treated
// as a miss.
module unique_value_set_table_unit #(
   parameter int unsigned CAPACITY = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  uvst_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output uvst_pkg::rsp_type rsp_data
);

   uvst_pkg::ctl_cmd_type  cmd;
   uvst_pkg::ctl_stat_type stat;

   // Sequence load, search walk, compaction walk and commit
   uvst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Hold the table, the count and the response payload
   uvst_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule

// ===== sim/unique_value_set_table_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for unique_value_set_table_unit: directed and random lookups, inserts
// and removes against a behavioral model of the packed value table. Depends on uvst_pkg.
module unique_value_set_table_unit_tb;
   import uvst_pkg::*;

   localparam int TABLE_DEPTH  = 64;
   localparam int RANDOM_ITEMS = 1700;
   localparam int VALUE_POOL   = 100;
   // Worst case per transaction is a single pass over a full table, search and compaction together, plus overhead.
   localparam int TAIL_CYCLES  = 4 * TABLE_DEPTH + 32;
   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int PRINT_LIMIT  = 40;

   // Operation code with no meaning; the block answers it as a miss.
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   typedef enum int {PHASE_FILL, PHASE_DRAIN, PHASE_MIXED} traffic_phase;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Model state: packed entries [0 .. held_count-1].
   logic signed [VALUE_W-1:0] held_values [TABLE_DEPTH];
   int                        held_count = 0;
   logic signed [VALUE_W-1:0] value_pool [VALUE_POOL];

   rsp_type awaited_results [$];
   rsp_type want_rsp;
   int      mismatch_count = 0;
   int      cycle_count = 0;
   int      sink_hold = 0;
   bit      steady_source = 1'b0;
   bit      steady_sink = 1'b0;

   unique_value_set_table_unit #(
      .CAPACITY(TABLE_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Abort a hung run; the limit is several times the slowest legal run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding", cycle_count,
                  awaited_results.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("[%0t] mismatch: %s", $time, what);
   endtask

   // Mostly short idle stretches, now and then a long one.
   function automatic int pick_idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Apply one request to the model table and return the response it must give.
   function automatic rsp_type predict_table_op(input req_type rq);
      rsp_type rs;
      int      hit;
      int      i;
      hit = -1;
      for (i = 0; i < held_count; i++) begin
         if (hit < 0 && held_values[i] == rq.value)
            hit = i;
      end
      rs.status   = ST_NOTFOUND;
      rs.position = '0;
      case (rq.operation)
         OP_LOOKUP: begin
            if (hit >= 0) begin
               rs.status   = ST_OK;
               rs.position = hit[POS_W-1:0];
            end
         end
         OP_INSERT: begin
            // Duplicate check wins over the full check.
            if (hit >= 0) begin
               rs.status = ST_DUP;
            end else if (held_count >= TABLE_DEPTH) begin
               rs.status = ST_FULL;
            end else begin
               held_values[held_count] = rq.value;
               rs.status   = ST_OK;
               rs.position = held_count[POS_W-1:0];
               held_count++;
            end
         end
         OP_REMOVE: begin
            if (hit >= 0) begin
               // Close the gap: every later entry moves down one slot.
               for (i = hit; i + 1 < held_count; i++)
                  held_values[i] = held_values[i + 1];
               held_count--;
               rs.status   = ST_OK;
               rs.position = hit[POS_W-1:0];
            end
         end
         default: begin
         end
      endcase
      rs.entry_count = held_count[COUNT_W-1:0];
      return rs;
   endfunction

   function automatic logic signed [VALUE_W-1:0] make_fresh_value();
      logic signed [VALUE_W-1:0] v;
      bit                        clash;
      int                        i;
      do begin
         v = $urandom;
         clash = 1'b0;
         for (i = 0; i < held_count; i++)
            if (held_values[i] == v)
               clash = 1'b1;
      end while (clash);
      return v;
   endfunction

   // Bias toward held values so lookups and removes hit often.
   function automatic logic signed [VALUE_W-1:0] pick_value(input logic [OP_W-1:0] op);
      int r;
      int hit_share;
      r = $urandom_range(0, 99);
      hit_share = (op == OP_INSERT) ? 20 : 65;
      if (held_count > 0 && r < hit_share)
         return held_values[$urandom_range(0, held_count - 1)];
      if (r < hit_share + 20)
         return value_pool[$urandom_range(0, VALUE_POOL - 1)];
      return $urandom;
   endfunction

   function automatic logic [OP_W-1:0] pick_op(input traffic_phase kind);
      int r;
      r = $urandom_range(0, 99);
      if (r < 4)
         return OP_UNUSED;
      case (kind)
         PHASE_FILL:  return (r < 70) ? OP_INSERT : (r < 85) ? OP_LOOKUP : OP_REMOVE;
         PHASE_DRAIN: return (r < 65) ? OP_REMOVE : (r < 85) ? OP_LOOKUP : OP_INSERT;
         default:     return (r < 36) ? OP_INSERT : (r < 68) ? OP_LOOKUP : OP_REMOVE;
      endcase
   endfunction

   // Present one request transaction and hold it until accepted. Valid stays high
   // on return; the next call or an idle task decides whether it drops.
   task automatic send_request(input logic [OP_W-1:0] op, input logic signed [VALUE_W-1:0] val);
      req_type rq;
      int      gap;
      rq.operation = op;
      rq.value     = val;
      gap = steady_source ? 0 : pick_idle_len();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= rq;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      awaited_results.push_back(predict_table_op(rq));
   endtask

   // Drop valid and hold off until every outstanding response has come back.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
   endtask

   // Response sink: random stalls of varied length, or none at all in steady stretches.
   always @(negedge clock) begin
      if (steady_sink) begin
         rsp_ready <= 1'b1;
         sink_hold = 0;
      end else if (sink_hold > 0) begin
         sink_hold = sink_hold - 1;
      end else if (rsp_ready) begin
         if ($urandom_range(0, 99) < 30) begin
            rsp_ready <= 1'b0;
            sink_hold = pick_idle_len();
         end
      end else begin
         rsp_ready <= 1'b1;
         sink_hold = $urandom_range(0, 6);
      end
   end

   // Compare each accepted response with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_results.size() == 0) begin
            report_mismatch($sformatf("response with none pending: status %0d pos %0d count %0d",
                                      rsp_data.status, rsp_data.position,
                                      rsp_data.entry_count));
         end else begin
            want_rsp = awaited_results.pop_front();
            if (rsp_data.status !== want_rsp.status)
               report_mismatch($sformatf("status got %0d want %0d",
                                         rsp_data.status, want_rsp.status));
            if (rsp_data.position !== want_rsp.position)
               report_mismatch($sformatf("position got %0d want %0d",
                                         rsp_data.position, want_rsp.position));
            if (rsp_data.entry_count !== want_rsp.entry_count)
               report_mismatch($sformatf("entry_count got %0d want %0d",
                                         rsp_data.entry_count, want_rsp.entry_count));
         end
      end
   end

   // Empty table: every operation misses, and the unused code is ignored.
   task automatic test_empty_table();
      send_request(OP_LOOKUP, 32'sd0);
      send_request(OP_REMOVE, -32'sd1);
      send_request(OP_UNUSED, 32'sd0);
   endtask

   // Extreme values, duplicates, head and tail removes with compaction, misses.
   task automatic test_extreme_values();
      send_request(OP_INSERT, 32'sh8000_0000);
      send_request(OP_INSERT, 32'sh7FFF_FFFF);
      send_request(OP_INSERT, 32'sd0);
      send_request(OP_INSERT, -32'sd1);
      send_request(OP_INSERT, 32'sh8000_0000);     // already held
      send_request(OP_LOOKUP, 32'sh7FFF_FFFF);
      send_request(OP_LOOKUP, -32'sd1);
      send_request(OP_LOOKUP, 32'sd1);             // absent
      send_request(OP_UNUSED, 32'sd0);             // held, still a miss
      send_request(OP_REMOVE, 32'sh8000_0000);     // head: shift the rest down
      send_request(OP_LOOKUP, -32'sd1);
      send_request(OP_REMOVE, -32'sd1);            // tail
      send_request(OP_REMOVE, -32'sd1);            // now absent
      send_request(OP_INSERT, 32'sh5555_5555);
      send_request(OP_INSERT, 32'shAAAA_AAAA);
      send_request(OP_REMOVE, 32'sh7FFF_FFFF);     // head again: shift the rest down
      send_request(OP_LOOKUP, 32'shAAAA_AAAA);
      send_request(OP_UNUSED, 32'shAAAA_AAAA);
      wait_drained();
   endtask

   // Fill to capacity, then hit the full-table cases and the longest compaction.
   task automatic test_full_table();
      while (held_count < TABLE_DEPTH)
         send_request(OP_INSERT, make_fresh_value());
      send_request(OP_INSERT, held_values[$urandom_range(0, TABLE_DEPTH - 1)]);
      send_request(OP_INSERT, make_fresh_value());
      send_request(OP_LOOKUP, held_values[TABLE_DEPTH - 1]);
      send_request(OP_UNUSED, held_values[0]);
      send_request(OP_REMOVE, held_values[0]);
      send_request(OP_INSERT, make_fresh_value());
      send_request(OP_REMOVE, held_values[TABLE_DEPTH - 1]);
      send_request(OP_LOOKUP, $urandom);
   endtask

   // Phases of fill, drain and mixed traffic with random content and idling.
   task automatic test_random_traffic();
      int           sent;
      int           span;
      int           r;
      traffic_phase kind;
      logic [OP_W-1:0] op;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         r = $urandom_range(0, 99);
         kind = (r < 40) ? PHASE_FILL : (r < 70) ? PHASE_DRAIN : PHASE_MIXED;
         span = $urandom_range(30, 160);
         steady_source = ($urandom_range(0, 3) == 0);
         steady_sink   = ($urandom_range(0, 3) == 0);
         repeat (span) begin
            op = pick_op(kind);
            send_request(op, pick_value(op));
            if (op != OP_UNUSED)
               sent++;
         end
         if ($urandom_range(0, 4) == 0)
            wait_drained();
      end
      steady_source = 1'b0;
      steady_sink   = 1'b0;
   endtask

   initial begin
      for (int i = 0; i < VALUE_POOL; i++)
         value_pool[i] = $urandom;
      value_pool[0] = 32'sh8000_0000;
      value_pool[1] = 32'sh7FFF_FFFF;
      value_pool[2] = 32'sd0;
      value_pool[3] = -32'sd1;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_extreme_values();
      test_full_table();
      wait_drained();
      test_random_traffic();

      // Let any stray response surface before the verdict.
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
